// ===== rtl/rbf_kernel_with_gradients_defines.svh =====
// assertion macros used by the top-level rtl
`ifndef RBF_KERNEL_WITH_GRADIENTS_DEFINES_SVH
`define RBF_KERNEL_WITH_GRADIENTS_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RBF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define RBF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rbf_pkg.sv =====
package rbf_pkg;

    localparam int ExpTableDepth = 64;
    localparam int AccW          = 38;
    localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};
    localparam logic [63:0] Ln2Q32   = 64'd2977044472;
    localparam logic [31:0] Log2eQ30 = 32'd1549082005;
    localparam logic [21:0] XClamp   = 22'(32 << 16);
    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    // configuration register indexes
    localparam logic [0:0] RegLengthScale    = 1'b0;
    localparam logic [0:0] RegSignalVariance = 1'b1;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_L2, ST_DIV_X, ST_Y, ST_POS, ST_INTERP_M, ST_INTERP_S,
        ST_KMUL, ST_KRND, ST_GMUL, ST_GSTART, ST_DIV_G, ST_DONE
    } t_back_state;

    // divider control between back end and the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } t_div_req;

    // one table entry, 2^(-i/depth) in Q.32 by truncated Taylor series
    function automatic logic [63:0] rom_entry(input int unsigned idx, input int unsigned depth);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [127:0] prod;
        z = 64'((64'(idx) * Ln2Q32) / 64'(depth));
        term = 64'd1 << 32;
        pos = term;
        neg = '0;
        for (int k = 1; k < 16; k++) begin
            prod = 128'(term) * 128'(z);
            term = 64'((prod >> 32) / 128'(k));
            if (k % 2 == 1) neg = neg + term;
            else pos = pos + term;
        end
        return pos - neg;
    endfunction

endpackage

// ===== rtl/rbf_kernel_with_gradients.sv =====
// channel   | dir | tdata fields (low bit up)               | tuser
// s_axis    | in  | coord_a[15:0], coord_b[31:16]            | last_coord via s_axis_tlast
// m_axis    | out | kernel_value[23:0], grad_log_length[55:24], distance_sq[93:56] | none
// cfg       | in  | index 0 length scale, 1 signal variance  | none
// coordinates are taken one per cycle while the four-entry distance queue has room
// the back end then takes one point pair at a time, with two restoring divisions each
// reset: synchronous, active low; clears accumulator, queue, sequencer, registers to 1.0
// a stalled output holds the back end; the front end keeps going until the queue fills
`include "rbf_kernel_with_gradients_defines.svh"
module rbf_kernel_with_gradients
    import rbf_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = ExpTableDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // coord_a, coord_b
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // kernel_value, grad_log_length, distance_sq
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic            w_push, w_full, w_pop, w_empty;
    logic [AccW-1:0] w_r2_in, w_r2_out, w_dist;
    logic [23:0]     w_k;
    logic [31:0]     w_g;
    logic [15:0]     r_ls, r_sv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ls <= 16'd256;
            r_sv <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegLengthScale:    r_ls <= i_cfg_data;
                RegSignalVariance: r_sv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rbf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_coord_a(s_axis_tdata[15:0]),
        .i_coord_b(s_axis_tdata[31:16]),
        .i_last   (s_axis_tlast),
        .o_push   (w_push),
        .i_full   (w_full),
        .o_r2     (w_r2_in)
    );

    rbf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_r2_in),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_data (w_r2_out)
    );

    rbf_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_r2       (w_r2_out),
        .o_pop      (w_pop),
        .i_len_scale(r_ls),
        .i_sig_var  (r_sv),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_kernel   (w_k),
        .o_grad     (w_g),
        .o_dist     (w_dist)
    );

    assign m_axis_tdata = {2'b00, w_dist, w_g, w_k};

    `RBF_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, w_full, !w_push, "push into full queue")
    `RBF_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, w_empty, !w_pop, "pop from empty queue")
    `RBF_ASSERT_NXT(a_pop_needs_room, i_clk, i_rst_n, w_pop, !m_axis_tvalid, "pop while output held")

endmodule

// ===== rtl/rbf_front.sv =====
module rbf_front
    import rbf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [15:0]     i_coord_a,
    input  logic [15:0]     i_coord_b,
    input  logic            i_last,
    output logic            o_push,
    input  logic            i_full,
    output logic [AccW-1:0] o_r2
);

    logic [AccW-1:0] r_acc, n_acc;
    logic [16:0]     w_diff, w_mag;
    logic [AccW:0]   w_sum;
    logic            w_acc;

    // one coordinate pair per cycle unless the queue is full
    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;
    assign w_diff  = {i_coord_a[15], i_coord_a} - {i_coord_b[15], i_coord_b};
    assign w_mag   = w_diff[16] ? (~w_diff + 17'd1) : w_diff;
    assign w_sum   = {1'b0, r_acc} + (AccW+1)'(w_mag * w_mag);

    // saturating accumulate, cleared on the last dimension
    always_comb begin
        n_acc = w_sum[AccW] ? AccMax : w_sum[AccW-1:0];
    end

    assign o_push = w_acc && i_last;
    assign o_r2   = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_acc) begin
            r_acc <= i_last ? '0 : n_acc;
        end
    end

endmodule

// ===== rtl/rbf_queue.sv =====
module rbf_queue
    import rbf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [AccW-1:0] i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [AccW-1:0] o_data
);

    logic [AccW-1:0]  r_mem [QueueDepth];
    logic [QueueAw:0] r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[QueueAw] != r_rp[QueueAw]) &&
                     (r_wp[QueueAw-1:0] == r_rp[QueueAw-1:0]);
    assign o_data  = r_mem[r_rp[QueueAw-1:0]];

    // small register file of pending point-pair distances
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp[QueueAw-1:0]] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end

endmodule

// ===== rtl/rbf_div.sv =====
module rbf_div
    import rbf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_busy,
    output logic [63:0] o_quo
);

    logic [63:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic [32:0] w_trial;
    logic [33:0] w_sub;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem[31:0], r_quo[63]};
    assign w_sub   = {1'b0, w_trial} - {2'b0, r_den};
    assign o_busy  = (r_cnt != 7'd0);
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= 7'd64;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (o_busy) begin
            if (!w_sub[33]) begin
                r_rem <= w_sub[32:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

endmodule

// ===== rtl/rbf_back.sv =====
module rbf_back
    import rbf_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = ExpTableDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  logic [AccW-1:0] i_r2,
    output logic            o_pop,
    input  logic [15:0]     i_len_scale,
    input  logic [15:0]     i_sig_var,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [23:0]     o_kernel,
    output logic [31:0]     o_grad,
    output logic [AccW-1:0] o_dist
);

    localparam int TW = $clog2(EXP_TABLE_DEPTH);
    localparam int IW = TW + 1;

    t_back_state r_st, n_st;
    t_div_req    w_req;
    logic        w_busy;
    logic [63:0] w_quo;

    logic [AccW-1:0] r_r2;
    logic [31:0]     r_l2;
    logic [21:0]     r_x;
    logic [53:0]     r_prod;
    logic [15:0]     r_n;
    logic [TW-1:0]   r_idx;
    logic [15:0]     r_wt;
    logic [32:0]     r_t0;
    logic [31:0]     r_dif;
    logic [47:0]     r_m;
    logic [32:0]     r_e;
    logic [47:0]     r_ke;
    logic [23:0]     r_k;
    logic [61:0]     r_kr;
    logic            r_oval;
    logic [23:0]     r_ok;
    logic [31:0]     r_og;
    logic [AccW-1:0] r_od;

    logic [63:0] w_tab [EXP_TABLE_DEPTH+1];
    logic [15:0] w_l;
    logic [31:0] w_pos;
    logic [32:0] w_t0, w_t1;
    logic [32:0] w_v;

    // exp table built at elaboration
    always_comb begin
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            w_tab[i] = rom_entry(i, EXP_TABLE_DEPTH);
        end
    end

    assign w_l   = (i_len_scale == 16'd0) ? 16'd1 : i_len_scale;
    assign w_pos = 32'(r_prod[45:30]) * 32'(EXP_TABLE_DEPTH);
    assign w_t0  = w_tab[IW'(r_idx)][32:0];
    assign w_t1  = w_tab[IW'(r_idx) + IW'(1)][32:0];
    assign w_v   = r_t0 - 33'(r_m[47:16]);

    // sequencer next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:     if (!i_empty && !r_oval) n_st = ST_L2;
            ST_L2:       n_st = ST_DIV_X;
            ST_DIV_X:    if (!w_busy) n_st = ST_Y;
            ST_Y:        n_st = ST_POS;
            ST_POS:      n_st = ST_INTERP_M;
            ST_INTERP_M: n_st = ST_INTERP_S;
            ST_INTERP_S: n_st = ST_KMUL;
            ST_KMUL:     n_st = ST_KRND;
            ST_KRND:     n_st = ST_GMUL;
            ST_GMUL:     n_st = ST_GSTART;
            ST_GSTART:   n_st = ST_DIV_G;
            ST_DIV_G:    if (!w_busy) n_st = ST_DONE;
            ST_DONE:     n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_req = '0;
        o_pop = 1'b0;
        unique case (r_st)
            ST_IDLE: o_pop = !i_empty && !r_oval;
            ST_L2: begin
                w_req.start = 1'b1;
                w_req.num   = 64'(r_r2) << 15;
                w_req.den   = r_l2;
            end
            ST_GSTART: begin
                w_req.start = 1'b1;
                w_req.num   = 64'(r_kr);
                w_req.den   = r_l2;
            end
            default: ;
        endcase
    end

    rbf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_busy (w_busy),
        .o_quo  (w_quo)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_r2 <= i_r2;
                r_l2 <= 32'(w_l) * 32'(w_l);
            end
            ST_DIV_X: r_x <= (w_quo > 64'(XClamp)) ? XClamp : w_quo[21:0];
            ST_Y:     r_prod <= 54'(r_x) * 54'(Log2eQ30);
            ST_POS: begin
                r_n   <= 16'(r_prod[53:46]);
                r_idx <= w_pos[16 +: TW];
                r_wt  <= w_pos[15:0];
            end
            ST_INTERP_M: begin
                r_t0  <= w_t0;
                r_dif <= (w_t0 > w_t1) ? 32'(w_t0 - w_t1) : 32'd0;
            end
            ST_INTERP_S: r_m <= r_dif * 48'(r_wt);
            ST_KMUL: begin
                r_e  <= (r_n >= 16'd48) ? 33'd0 : (w_v >> r_n[5:0]);
            end
            ST_KRND:  r_ke <= 48'(i_sig_var) * 48'(r_e) + 48'(1 << 23);
            ST_GMUL: begin
                r_k  <= r_ke[47:24];
            end
            default: ;
        endcase
        if (r_st == ST_GMUL) r_kr <= 62'(r_ke[47:24]) * 62'(r_r2);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (r_st == ST_DONE) begin
            r_oval <= 1'b1;
        end else if (i_ready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_DONE) begin
            r_ok <= r_k;
            r_og <= (w_quo[63:32] != 32'd0) ? 32'hFFFF_FFFF : w_quo[31:0];
            r_od <= r_r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else          r_st <= n_st;
    end

    assign o_valid  = r_oval;
    assign o_kernel = r_ok;
    assign o_grad   = r_og;
    assign o_dist   = r_od;

endmodule

// ===== sim/tb_rbf_kernel_with_gradients.sv =====
module tb_rbf_kernel_with_gradients;
    import rbf_pkg::*;

    localparam int LIMIT = 4000000;
    localparam logic [37:0] ACC_MAX = {38{1'b1}};

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // coord_a[15:0], coord_b[31:16]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // kernel_value[23:0], grad_log_length[55:24], distance_sq[93:56]
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    rbf_kernel_with_gradients dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // packed high field first: distance on top, kernel value at the bottom
    typedef struct packed {
        logic [37:0] dsq;
        logic [31:0] grad;
        logic [23:0] kval;
    } t_kernel_out;

    typedef struct {
        logic [15:0] a;
        logic [15:0] b;
        logic        last;
        logic        has_known;
        logic [23:0] known_kval;
    } t_coord_row;

    // predictor state
    logic [15:0] len_scale;
    logic [15:0] sig_var;
    logic [37:0] r2_accum;
    logic [63:0] exp_rom [0:64];
    t_kernel_out kernel_q[$];
    t_coord_row  rows[$];

    int  errors;
    int  cycles;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  rx_hold;
    bit  hold_go;
    bit  stim_done;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // table of 2^(-i/64) in Q.32 built by truncated series
    function automatic logic [63:0] series_exp2(input int idx);
        logic [63:0]  z;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [127:0] prod;
        z = (64'(idx) * 64'd2977044472) / 64'd64;
        term = 64'd1 << 32;
        pos = term;
        neg = '0;
        for (int k = 1; k < 16; k++) begin
            prod = 128'(term) * 128'(z);
            term = 64'((prod >> 32) / 128'(k));
            if (k % 2 == 1) neg += term;
            else pos += term;
        end
        return pos - neg;
    endfunction

    // one coordinate pair into the distance accumulator, result on last
    function automatic bit predict_kernel(input logic [15:0] a, input logic [15:0] b,
                                          input logic last, output t_kernel_out res);
        logic signed [17:0] d;
        logic [63:0]  sq;
        logic [63:0]  sum;
        logic [63:0]  l;
        logic [63:0]  l2;
        logic [63:0]  x;
        logic [127:0] y;
        logic [63:0]  n;
        logic [63:0]  f;
        logic [63:0]  idx;
        logic [63:0]  wt;
        logic [63:0]  t0;
        logic [63:0]  t1;
        logic [63:0]  df;
        logic [63:0]  e;
        logic [127:0] kk;
        logic [127:0] g;
        d = 18'(signed'(a)) - 18'(signed'(b));
        sq = (d < 0) ? 64'(-d) : 64'(d);
        sq = sq * sq;
        sum = 64'(r2_accum) + sq;
        r2_accum = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[37:0];
        if (!last) return 0;
        l = (len_scale == 0) ? 64'd1 : 64'(len_scale);
        l2 = l * l;
        x = (64'(r2_accum) << 15) / l2;
        if (x > (64'd32 << 16)) x = 64'd32 << 16;
        y = (128'(x) * 128'd1549082005) >> 30;
        n = 64'(y >> 16);
        f = 64'(y) & 64'hFFFF;
        if (n >= 48) begin
            e = 0;
        end else begin
            idx = (f * 64) >> 16;
            wt = (f * 64) & 64'hFFFF;
            t0 = exp_rom[idx];
            t1 = exp_rom[idx + 1];
            df = (t0 > t1) ? t0 - t1 : 0;
            e = (t0 - ((df * wt) >> 16)) >> n;
        end
        kk = (128'(sig_var) * 128'(e) + (128'd1 << 23)) >> 24;
        if (kk > 128'hFFFFFF) kk = 128'hFFFFFF;
        g = (kk * 128'(r2_accum)) / 128'(l2);
        if (g > 128'hFFFFFFFF) g = 128'hFFFFFFFF;
        res.kval = kk[23:0];
        res.grad = g[31:0];
        res.dsq = r2_accum;
        r2_accum = '0;
        return 1;
    endfunction

    // register write while idle
    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == RegLengthScale) len_scale = val;
        else sig_var = val;
    endtask

    task automatic wait_drained();
        while (kernel_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // drive one request and predict its result
    task automatic send_coord(input logic [15:0] a, input logic [15:0] b, input logic last,
                              input bit has_known, input logic [23:0] known_kval);
        t_kernel_out res;
        while ($urandom_range(99) < tx_idle_pct) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {b, a};
        s_axis_tlast = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (predict_kernel(a, b, last, res)) begin
            if (has_known && res.kval != known_kval) begin
                $display("%0t table row kval expected %h predictor %h",
                         $time, known_kval, res.kval);
                errors++;
            end
            kernel_q.push_back(res);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // random point pair, mostly small dimension counts and near points
    task automatic send_pair();
        int dims;
        logic [15:0] a;
        logic [15:0] b;
        dims = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(4, 1);
        for (int i = 0; i < dims; i++) begin
            a = $urandom;
            case ($urandom_range(3))
                0: b = $urandom;
                1: b = a + 16'($urandom_range(1023)) - 16'd512;
                2: b = a + 16'($urandom_range(63)) - 16'd32;
                default: b = a;
            endcase
            send_coord(a, b, i == dims - 1, 0, '0);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_kernel_out got;
        t_kernel_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[93:0];
            if (kernel_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
            end else begin
                want = kernel_q.pop_front();
                if (got.kval !== want.kval) begin
                    $display("%0t kernel_value expected %h actual %h", $time, want.kval, got.kval);
                    errors++;
                end
                if (got.grad !== want.grad) begin
                    $display("%0t grad_log_length expected %h actual %h",
                             $time, want.grad, got.grad);
                    errors++;
                end
                if (got.dsq !== want.dsq) begin
                    $display("%0t distance_sq expected %h actual %h", $time, want.dsq, got.dsq);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off counted here, while the sender keeps going
    initial begin
        rx_hold = 1'b0;
        wait (hold_go && stim_done == 0);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (3000) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        stim_done = 0;
        hold_go = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = RegLengthScale;
        i_cfg_data = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        len_scale = 16'd256;
        sig_var = 16'd256;
        r2_accum = '0;
        for (int i = 0; i <= 64; i++) exp_rom[i] = series_exp2(i);
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero distance gives sf2 exactly, extremes, saturation
        rows.push_back('{16'h0000, 16'h0000, 1, 1, 24'h010000});
        rows.push_back('{16'h7FFF, 16'h7FFF, 1, 1, 24'h010000});
        rows.push_back('{16'h0100, 16'h0000, 1, 0, 0});
        rows.push_back('{16'h0000, 16'h0100, 0, 0, 0});
        rows.push_back('{16'h0080, 16'hFF80, 1, 0, 0});
        rows.push_back('{16'h7FFF, 16'h8000, 1, 1, 24'h000000});
        rows.push_back('{16'hFFFF, 16'h0000, 0, 0, 0});
        rows.push_back('{16'h5555, 16'hAAAA, 1, 0, 0});
        for (int i = 0; i < 70; i++) begin
            rows.push_back('{16'h7FFF, 16'h8000, 0, 0, 0});
        end
        rows.push_back('{16'h7FFF, 16'h8000, 1, 1, 24'h000000});
        foreach (rows[i])
            send_coord(rows[i].a, rows[i].b, rows[i].last, rows[i].has_known,
                       rows[i].known_kval);
        rows.delete();
        wait_drained();

        // zero length scale, maximum variance, extreme registers
        write_reg(RegLengthScale, 16'd0);
        write_reg(RegSignalVariance, 16'hFFFF);
        send_coord(16'h0000, 16'h0000, 1, 1, 24'hFFFF00);
        send_coord(16'h0001, 16'h0000, 1, 0, '0);
        send_coord(16'h0004, 16'h0000, 1, 0, '0);
        wait_drained();
        write_reg(RegLengthScale, 16'hFFFF);
        write_reg(RegSignalVariance, 16'h0000);
        send_coord(16'h7FFF, 16'h8000, 1, 1, 24'h000000);
        wait_drained();

        // random phases across settings and idle profiles
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: begin tx_idle_pct = 27; rx_idle_pct = 71; end
                1: begin tx_idle_pct = 71; rx_idle_pct = 27; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            case (ph)
                0: write_reg(RegLengthScale, 16'd256);
                3: write_reg(RegLengthScale, 16'd1);
                6: write_reg(RegLengthScale, 16'hFFFF);
                default: write_reg(RegLengthScale, 16'($urandom_range(4096, 16)));
            endcase
            write_reg(RegSignalVariance, (ph == 4) ? 16'hFFFF : 16'($urandom));
            if (ph == 2) hold_go = 1;
            for (int p = 0; p < 42; p++) send_pair();
            // pause until all results are in
            if (ph == 2) wait_drained();
            wait_drained();
        end

        stim_done = 1;
        wait_drained();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rbf_pkg.sv
rtl/rbf_front.sv
rtl/rbf_queue.sv
rtl/rbf_div.sv
rtl/rbf_back.sv
rtl/rbf_kernel_with_gradients.sv
sim/tb_rbf_kernel_with_gradients.sv
